### hw/rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared constants and types for the shortest common supersequence length
// unit: field widths, parameter defaults and the controller command bundle.
// ----------------------------------------------------------------------------
package scs_pkg;

   // Widths fixed by the transaction fields.
   localparam int STRAND_IN_W = 64;
   localparam int CELL_W      = 7;

   // Parameter defaults and the largest supported strand length.
   localparam int DEF_SEQ_LEN     = 32;
   localparam int DEF_SYMBOL_BITS = 2;
   localparam int MAX_SEQ_LEN     = 32;

   // The wavefront step counter runs up to 2*MAX_SEQ_LEN-1.
   localparam int STEP_W = $clog2(2 * MAX_SEQ_LEN);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load;
      logic              step;
      logic              capture;
      logic [STEP_W-1:0] step_num;
   } scs_cmd_type;

endpackage

### hw/rtl/scs_datapath.sv
// ----------------------------------------------------------------------------
// scs_datapath
// Wavefront datapath: one lane per table column. On each step every active
// lane computes its next table cell from the left, upper and diagonal cells,
// while the first strand's symbols ripple across the lanes.
// ----------------------------------------------------------------------------
module scs_datapath
   import scs_pkg::*;
#(
   parameter int SEQ_LEN     = DEF_SEQ_LEN,
   parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
   input  logic                   clock,
   input  scs_cmd_type            cmd,
   input  logic [STRAND_IN_W-1:0] first_strand,
   input  logic [STRAND_IN_W-1:0] second_strand,
   output logic [CELL_W-1:0]      result
);

   localparam int STRAND_W = SEQ_LEN * SYMBOL_BITS;

   logic [STRAND_W-1:0]    a_ff;
   logic [STRAND_W-1:0]    b_ff;
   logic [SYMBOL_BITS-1:0] sym_ff [SEQ_LEN];
   logic [CELL_W-1:0]      col_ff [SEQ_LEN];
   logic [CELL_W-1:0]      old_ff [SEQ_LEN];
   logic [CELL_W-1:0]      result_ff;

   logic [STRAND_W+STRAND_IN_W-1:0] a_wide;
   logic [STRAND_W+STRAND_IN_W-1:0] b_wide;
   logic [CELL_W-1:0]               border_cell;

   // Symbols above bit 63 read as zero: pad, then keep the strand width.
   assign a_wide = {{STRAND_W{1'b0}}, first_strand};
   assign b_wide = {{STRAND_W{1'b0}}, second_strand};

   // Column zero of the table holds the row number, which equals the step.
   assign border_cell = {{(CELL_W-STEP_W){1'b0}}, cmd.step_num};

   // Strand registers: the first strand shifts one symbol per step.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= a_wide[STRAND_W-1:0];
         b_ff <= b_wide[STRAND_W-1:0];
      end else if (cmd.step) begin
         a_ff <= a_ff >> SYMBOL_BITS;
      end
   end

   for (genvar idx = 0; idx < SEQ_LEN; idx++) begin : g_lane
      localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(idx + 1);
      localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(SEQ_LEN + idx);

      logic [SYMBOL_BITS-1:0] sym_a;
      logic [SYMBOL_BITS-1:0] sym_b;
      logic [CELL_W-1:0]      left;
      logic [CELL_W-1:0]      diag;
      logic [CELL_W-1:0]      up;
      logic [CELL_W-1:0]      cell_val;
      logic                   active;

      // Left and diagonal neighbors come from the lane before, or the border.
      if (idx == 0) begin : g_edge
         assign sym_a = a_ff[SYMBOL_BITS-1:0];
         assign left  = border_cell;
         assign diag  = border_cell - CELL_W'(1);
      end else begin : g_inner
         assign sym_a = sym_ff[idx-1];
         assign left  = col_ff[idx-1];
         assign diag  = old_ff[idx-1];
      end

      assign sym_b  = b_ff[idx*SYMBOL_BITS +: SYMBOL_BITS];
      assign up     = col_ff[idx];
      assign active = (cmd.step_num >= FIRST_STEP) && (cmd.step_num <= LAST_STEP);

      // Cell update: diagonal plus one on a match, else smaller neighbor plus one.
      always_comb begin
         if (sym_a == sym_b) begin
            cell_val = diag + CELL_W'(1);
         end else if (up < left) begin
            cell_val = up + CELL_W'(1);
         end else begin
            cell_val = left + CELL_W'(1);
         end
      end

      // Lane registers: the row zero border is loaded, then cells advance.
      always_ff @(posedge clock) begin
         if (cmd.load) begin
            col_ff[idx] <= CELL_W'(idx + 1);
            old_ff[idx] <= '0;
            sym_ff[idx] <= '0;
         end else if (cmd.step) begin
            sym_ff[idx] <= sym_a;
            if (active) begin
               old_ff[idx] <= up;
               col_ff[idx] <= cell_val;
            end
         end
      end
   end

   // Result register: the bottom right cell of the table.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         result_ff <= col_ff[SEQ_LEN-1];
      end
   end

   assign result = result_ff;

endmodule

### hw/rtl/scs_ctrl.sv
// ----------------------------------------------------------------------------
// scs_ctrl
// Controller: accepts a request transaction, sequences the wavefront steps
// of the datapath, and hands the finished length to the response register.
// ----------------------------------------------------------------------------
module scs_ctrl
   import scs_pkg::*;
#(
   parameter int SEQ_LEN = DEF_SEQ_LEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output scs_cmd_type cmd
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * SEQ_LEN - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WRITE
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and step count.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               step_in  = STEP_W'(1);
            end
         end
         ST_RUN: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_WRITE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Commands to the datapath.
   assign cmd.load     = accept;
   assign cmd.step     = (state_ff == ST_RUN);
   assign cmd.capture  = (state_ff == ST_WRITE) && out_free;
   assign cmd.step_num = step_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A result is only written into a free or draining response register.
   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (!rsp_valid_ff || rsp_ready))
      else $error("result captured over an unread response");

   // An accepted request starts the sweep at step one.
   a_start_step: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_RUN && step_ff == STEP_W'(1)))
      else $error("sweep did not start at step one");

   // While sweeping, the step count stays within the wavefront range.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff >= STEP_W'(1) && step_ff <= LAST_STEP))
      else $error("step count out of range");

   // The response goes valid only right after a capture.
   a_rsp_after_capture: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.capture))
      else $error("response valid without a capture");

endmodule

### hw/rtl/scs_length_dp_unit.sv
// ----------------------------------------------------------------------------
// scs_length_dp_unit
// Shortest common supersequence length of two equal-length strands.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction carries two strands of SEQ_LEN symbols of
//   SYMBOL_BITS bits each, symbol 0 in the low bits; symbols above bit 63
//   read as zero. Each request yields exactly one response transaction
//   carrying the supersequence length.
//   The table is swept along anti-diagonals: one lane per column, so one
//   wavefront step per cycle and 2*SEQ_LEN-1 steps per request.
//   req_ready is high only while the unit is idle. A finished response sits
//   in its output register, and the next request is accepted while it waits.
//   If the receiver stalls, the following result waits inside the unit until
//   the output register is free.
//   Reset (synchronous, active high) returns the unit to idle and drops
//   rsp_valid; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module scs_length_dp_unit
   import scs_pkg::*;
#(
   parameter int SEQ_LEN     = DEF_SEQ_LEN,
   parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [STRAND_IN_W-1:0] req_first_strand,
   input  logic [STRAND_IN_W-1:0] req_second_strand,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CELL_W-1:0]      rsp_supersequence_length
);

   scs_cmd_type cmd;

   // Sequencer for load, sweep and response.
   scs_ctrl #(
      .SEQ_LEN (SEQ_LEN)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Column lanes and result register.
   scs_datapath #(
      .SEQ_LEN     (SEQ_LEN),
      .SYMBOL_BITS (SYMBOL_BITS)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .first_strand  (req_first_strand),
      .second_strand (req_second_strand),
      .result        (rsp_supersequence_length)
   );

endmodule
